[rtl/tsdr_pkg.sv]
// Package for the touch swipe direction repeat block.
// Holds gesture codes, register indexes and the item and configuration types.
// No dependencies.
`default_nettype none

package tsdr_pkg;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_RIGHT = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_DOWN  = 3'd3,
        DIR_UP    = 3'd4
    } tsdr_dir_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_UPDATE_INTERVAL       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOVE_THRESHOLD        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_REPEAT_INTERVAL = 2'd2;

    localparam logic [15:0] RST_UPDATE_INTERVAL       = 16'd50;
    localparam logic [15:0] RST_MOVE_THRESHOLD        = 16'd10;
    localparam logic [15:0] RST_FIRST_REPEAT_INTERVAL = 16'd300;

    localparam logic [7:0] REPEAT_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [31:0] now_ms;
    } tsdr_item_t;

    typedef struct packed {
        logic [15:0] update_interval;
        logic [15:0] move_threshold;
        logic [15:0] first_repeat_interval;
    } tsdr_cfg_t;

endpackage

`default_nettype wire

[rtl/touch_swipe_direction_repeat.sv]
// Top level of the touch swipe direction repeat block: input register,
// configuration registers, result register. Depends on tsdr_pkg, tsdr_tracker.
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_valid / s_ready   | s_pos_x, s_pos_y, s_now_ms
//   m_      | out       | m_valid / m_ready   | m_gesture
//   cfg_    | in        | cfg_wr_en           | cfg_index, cfg_wdata
//
// One item per cycle sustained while no result is stalled; each accepted item
// passes the input register, then the result register after the tracker logic.
// Reset clears the tracking state, the configuration to its defaults and
// both valid flags. A stalled result holds in the result register while one
// more item waits in the input register; s_ready drops only when both are full.
`default_nettype none

module touch_swipe_direction_repeat (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [15:0]                        s_pos_x,
    input  wire logic [15:0]                        s_pos_y,
    input  wire logic [31:0]                        s_now_ms,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [2:0]                              m_gesture,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tsdr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tsdr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tsdr_pkg::*;

    tsdr_cfg_t  cfg_reg;
    tsdr_item_t in_item_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    tsdr_dir_t  out_gesture_reg;
    tsdr_dir_t  gesture;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.update_interval       <= RST_UPDATE_INTERVAL;
            cfg_reg.move_threshold        <= RST_MOVE_THRESHOLD;
            cfg_reg.first_repeat_interval <= RST_FIRST_REPEAT_INTERVAL;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_UPDATE_INTERVAL:       cfg_reg.update_interval       <= cfg_wdata;
                REG_MOVE_THRESHOLD:        cfg_reg.move_threshold        <= cfg_wdata;
                REG_FIRST_REPEAT_INTERVAL: cfg_reg.first_repeat_interval <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.pos_x  <= s_pos_x;
            in_item_reg.pos_y  <= s_pos_y;
            in_item_reg.now_ms <= s_now_ms;
        end
    end

    tsdr_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .gesture (gesture)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_gesture_reg <= gesture;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_gesture = out_gesture_reg;

endmodule

`default_nettype wire

[rtl/tsdr_classify.sv]
// Movement classifier: dominant axis direction from the position delta.
// Depends on tsdr_pkg.
`default_nettype none

module tsdr_classify (
    input  wire logic [15:0]        pos_x,
    input  wire logic [15:0]        pos_y,
    input  wire logic [15:0]        prev_x,
    input  wire logic [15:0]        prev_y,
    input  wire logic [15:0]        move_threshold,
    output tsdr_pkg::tsdr_dir_t     dir
);
    import tsdr_pkg::*;

    logic [15:0] abs_x;
    logic [15:0] abs_y;

    assign abs_x = (pos_x >= prev_x) ? (pos_x - prev_x) : (prev_x - pos_x);
    assign abs_y = (pos_y >= prev_y) ? (pos_y - prev_y) : (prev_y - pos_y);

    always_comb begin
        if ((abs_x < move_threshold) && (abs_y < move_threshold)) begin
            dir = DIR_NONE;
        end else if (abs_x >= abs_y) begin
            dir = (pos_x > prev_x) ? DIR_RIGHT : DIR_LEFT;
        end else begin
            dir = (pos_y > prev_y) ? DIR_DOWN : DIR_UP;
        end
    end

endmodule

`default_nettype wire

[rtl/tsdr_tracker.sv]
// Touch tracking state and repeat timing; one item per step.
// Depends on tsdr_pkg and tsdr_classify.
`default_nettype none

module tsdr_tracker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  tsdr_pkg::tsdr_item_t     item,
    input  tsdr_pkg::tsdr_cfg_t      cfg,
    output tsdr_pkg::tsdr_dir_t      gesture
);
    import tsdr_pkg::*;

    logic        touching_reg, touching_next;
    logic [15:0] prev_x_reg, prev_x_next;
    logic [15:0] prev_y_reg, prev_y_next;
    logic [31:0] eval_stamp_reg, eval_stamp_next;
    tsdr_dir_t   held_reg, held_next;
    logic [31:0] emit_stamp_reg, emit_stamp_next;
    logic [7:0]  count_reg, count_next;
    logic        skip_reg, skip_next;

    tsdr_dir_t   dir;
    logic        released;
    logic [31:0] eval_elapsed;
    logic [31:0] emit_elapsed;
    logic [15:0] need;

    tsdr_classify u_classify (
        .pos_x          (item.pos_x),
        .pos_y          (item.pos_y),
        .prev_x         (prev_x_reg),
        .prev_y         (prev_y_reg),
        .move_threshold (cfg.move_threshold),
        .dir            (dir)
    );

    assign released     = (item.pos_x == 16'd0) && (item.pos_y == 16'd0);
    assign eval_elapsed = item.now_ms - eval_stamp_reg;
    assign emit_elapsed = item.now_ms - emit_stamp_reg;
    assign need         = (count_reg == 8'd1) ? cfg.first_repeat_interval
                                              : cfg.update_interval;

    always_comb begin
        touching_next   = touching_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        eval_stamp_next = eval_stamp_reg;
        held_next       = held_reg;
        emit_stamp_next = emit_stamp_reg;
        count_next      = count_reg;
        skip_next       = skip_reg;
        gesture         = DIR_NONE;
        if (released) begin
            if (touching_reg) begin
                touching_next = 1'b0;
                held_next     = DIR_NONE;
                count_next    = 8'd0;
                skip_next     = 1'b0;
            end
        end else if (!touching_reg) begin
            touching_next   = 1'b1;
            prev_x_next     = item.pos_x;
            prev_y_next     = item.pos_y;
            eval_stamp_next = item.now_ms;
            held_next       = DIR_NONE;
            count_next      = 8'd0;
            skip_next       = 1'b1;
        end else if (eval_elapsed >= {16'd0, cfg.update_interval}) begin
            eval_stamp_next = item.now_ms;
            prev_x_next     = item.pos_x;
            prev_y_next     = item.pos_y;
            if (skip_reg) begin
                skip_next = 1'b0;
            end else if (dir != DIR_NONE) begin
                if (dir != held_reg) begin
                    held_next       = dir;
                    count_next      = 8'd1;
                    emit_stamp_next = item.now_ms;
                    gesture         = dir;
                end else if (emit_elapsed >= {16'd0, need}) begin
                    if (count_reg != REPEAT_MAX) begin
                        count_next = count_reg + 8'd1;
                    end
                    emit_stamp_next = item.now_ms;
                    gesture         = dir;
                end
            end else begin
                held_next  = DIR_NONE;
                count_next = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touching_reg   <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            eval_stamp_reg <= '0;
            held_reg       <= DIR_NONE;
            emit_stamp_reg <= '0;
            count_reg      <= '0;
            skip_reg       <= 1'b0;
        end else if (step) begin
            touching_reg   <= touching_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            eval_stamp_reg <= eval_stamp_next;
            held_reg       <= held_next;
            emit_stamp_reg <= emit_stamp_next;
            count_reg      <= count_next;
            skip_reg       <= skip_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tsdr_checker.sv]
// Port-level checker for touch_swipe_direction_repeat, bound to the top level.
// Depends on tsdr_pkg.
`default_nettype none

module tsdr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_gesture
);
    import tsdr_pkg::*;

    a_gesture_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gesture <= DIR_UP))
        else $error("gesture code out of range");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result waiting");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_gesture)))
        else $error("stalled result changed");

    a_input_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> ##1 m_valid)
        else $error("accepted item gave no result");

endmodule

bind touch_swipe_direction_repeat tsdr_checker u_tsdr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_gesture (m_gesture)
);

`default_nettype wire
